FILE: rtl/core/spvg_pkg.sv
// star polygon vertex generator: shared types, constants and tables
// no dependencies; imported by every module of the block
package spvg_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 23;
    localparam int ANGLE_W    = 16;
    localparam int RAYS_W     = 6;
    localparam int VIDX_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // ray limits
    localparam int MIN_RAYS = 3;
    localparam int MAX_RAYS = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd3;

    // register reset values
    localparam logic [RAYS_W-1:0]   RST_RAY_COUNT    = 6'd5;
    localparam logic [RADIUS_W-1:0] RST_OUTER_RADIUS = 23'd2560;
    localparam logic [RADIUS_W-1:0] RST_INNER_RADIUS = 23'd1024;
    localparam logic [ANGLE_W-1:0]  RST_START_ANGLE  = 16'd0;

    // rotator
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int ATAN_W           = 26;
    localparam int ROT_W            = 32;
    localparam int GAIN_W           = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
    localparam int PROD_W           = RADIUS_W + GAIN_W;
    localparam int PROD_SH          = 24;
    localparam int START_W          = PROD_W - PROD_SH;
    localparam int GUARD_SH         = 6;
    localparam int SUM_W            = ROT_W - GUARD_SH + 1;

    // vertex angle offset sequencing, 65536 / (2 * rays)
    localparam int OFFSET_W = 16;
    localparam int DIVR_W   = 7;
    localparam int REM_W    = 6;
    localparam int DIV_W    = 17;
    localparam logic [DIV_W-1:0] DIV_DIVIDEND = 17'h10000;

    // arctangent of 2^-k in units of 2^-28 turn
    function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] k);
        logic [ATAN_W-1:0] v;
        case (k)
            5'd0:  v = 26'd33554432;
            5'd1:  v = 26'd19808338;
            5'd2:  v = 26'd10466182;
            5'd3:  v = 26'd5312797;
            5'd4:  v = 26'd2666708;
            5'd5:  v = 26'd1334654;
            5'd6:  v = 26'd667490;
            5'd7:  v = 26'd333765;
            5'd8:  v = 26'd166885;
            5'd9:  v = 26'd83443;
            5'd10: v = 26'd41721;
            5'd11: v = 26'd20861;
            5'd12: v = 26'd10430;
            5'd13: v = 26'd5215;
            5'd14: v = 26'd2608;
            5'd15: v = 26'd1304;
            5'd16: v = 26'd652;
            5'd17: v = 26'd326;
            5'd18: v = 26'd163;
            5'd19: v = 26'd81;
            5'd20: v = 26'd41;
            5'd21: v = 26'd20;
            5'd22: v = 26'd10;
            5'd23: v = 26'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // payloads
    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [VIDX_W-1:0]         vertex_index;
        logic                      last_vertex;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_START,
        S_ROT,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic rot_start;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic rot_done;
        logic out_free;
        logic last;
    } t_status;

endpackage

FILE: rtl/core/spvg_div.sv
// serial restoring divider: 65536 / divisor, one quotient bit per cycle
// depends on spvg_pkg
module spvg_div
    import spvg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [OFFSET_W-1:0] o_quot,
    output logic [REM_W-1:0]  o_rem
);

    localparam int DCNT_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_num;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_den;
    logic [DIVR_W-1:0] w_shift;
    logic              w_ge;

    // trial subtract of the shifted partial remainder
    assign w_shift = {r_rem[DIVR_W-2:0], r_num[DIV_W-1]};
    assign w_ge    = (w_shift >= r_den);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIV_DIVIDEND;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? (w_shift - r_den) : w_shift;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[OFFSET_W-1:0];
    assign o_rem  = r_rem[REM_W-1:0];

endmodule

FILE: rtl/core/spvg_cordic.sv
// iterative cordic rotator, one micro-rotation per cycle
// depends on spvg_pkg
module spvg_cordic
    import spvg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [START_W-1:0]      i_mag,
    input  logic [ANGLE_W-1:0]      i_angle,
    output logic                    o_done,
    output logic signed [ROT_W-1:0] o_x,
    output logic signed [ROT_W-1:0] o_y
);

    localparam int KW = $clog2(CORDIC_STEPS);
    localparam logic signed [ANGLE_W-1:0] ANG_QUARTER = 16'sd16384;
    localparam logic signed [ROT_W-1:0]   PH_HALF     = 32'sd134217728;

    logic                    r_busy;
    logic                    r_done;
    logic [KW-1:0]           r_k;
    logic signed [ROT_W-1:0] r_x;
    logic signed [ROT_W-1:0] r_y;
    logic signed [ROT_W-1:0] r_z;

    logic signed [ANGLE_W-1:0] w_sa;
    logic signed [ROT_W-1:0]   w_z0;
    logic signed [ROT_W-1:0]   w_x0;
    logic signed [ROT_W-1:0]   w_mag;
    logic signed [ROT_W-1:0]   w_dx;
    logic signed [ROT_W-1:0]   w_dy;
    logic signed [ROT_W-1:0]   w_atan;

    // fold the start angle into the right half plane
    assign w_sa  = signed'(i_angle);
    assign w_mag = signed'({{(ROT_W-START_W){1'b0}}, i_mag});

    always_comb begin
        w_z0 = signed'({{(ROT_W-ANGLE_W-12){i_angle[ANGLE_W-1]}}, i_angle, 12'b0});
        w_x0 = w_mag;
        if (w_sa > ANG_QUARTER) begin
            w_z0 = w_z0 - PH_HALF;
            w_x0 = -w_mag;
        end else if (w_sa < -ANG_QUARTER) begin
            w_z0 = w_z0 + PH_HALF;
            w_x0 = -w_mag;
        end
    end

    // micro-rotation terms
    assign w_dx   = r_y >>> r_k;
    assign w_dy   = r_x >>> r_k;
    assign w_atan = signed'({{(ROT_W-ATAN_W){1'b0}}, atan_val(ATAN_IDX_W'(r_k))});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + KW'(1);
                if (r_k == KW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotator registers, zero residual counts as positive
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= w_x0;
            r_y <= '0;
            r_z <= w_z0;
        end else if (r_busy) begin
            if (!r_z[ROT_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

FILE: rtl/core/spvg_dp.sv
// datapath: config registers, angle sequencing, start vector, rotator, output register
// depends on spvg_pkg, spvg_div, spvg_cordic
module spvg_dp
    import spvg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    // config registers
    logic [RAYS_W-1:0]   r_rays;
    logic [RADIUS_W-1:0] r_outer;
    logic [RADIUS_W-1:0] r_inner;
    logic [ANGLE_W-1:0]  r_start;

    // per-item and per-vertex registers
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [VIDX_W-1:0]   r_count;
    logic [OFFSET_W-1:0] r_off;
    logic [REM_W-1:0]    r_rem;
    logic [ANGLE_W-1:0]  r_angle;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [RAYS_W-1:0]   w_rays_wr;
    logic [RADIUS_W-1:0] w_rad_wr;
    logic [DIVR_W-1:0]   w_divisor;
    logic                w_div_done;
    logic [OFFSET_W-1:0] w_inc_q;
    logic [REM_W-1:0]    w_inc_r;
    logic [DIVR_W-1:0]   w_rem_sum;
    logic                w_wrap;
    logic [RADIUS_W-1:0] w_radius;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_round;
    logic                w_rot_done;
    logic signed [ROT_W-1:0]   w_rx;
    logic signed [ROT_W-1:0]   w_ry;
    logic signed [COORD_W-1:0] w_vx;
    logic signed [COORD_W-1:0] w_vy;

    // rotator output rounded off the guard bits, plus centre, saturated
    function automatic logic signed [COORD_W-1:0] place(
        input logic signed [ROT_W-1:0]   v,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [ROT_W-1:0] rnd;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vmin;
        rnd  = v + ROT_W'(32'sd32);
        sum  = SUM_W'(rnd >>> GUARD_SH) + SUM_W'(c);
        vmax = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
        vmin = -vmax - SUM_W'(1);
        if (sum > vmax) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum < vmin) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return sum[COORD_W-1:0];
    endfunction

    // clamped write values
    always_comb begin
        w_rays_wr = i_cfg_data[RAYS_W-1:0];
        if (w_rays_wr < RAYS_W'(MIN_RAYS)) begin
            w_rays_wr = RAYS_W'(MIN_RAYS);
        end else if (w_rays_wr > RAYS_W'(MAX_RAYS)) begin
            w_rays_wr = RAYS_W'(MAX_RAYS);
        end
        w_rad_wr = i_cfg_data[RADIUS_W-1:0];
        if (w_rad_wr == '0) begin
            w_rad_wr = RADIUS_W'(1);
        end
    end

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rays  <= RST_RAY_COUNT;
            r_outer <= RST_OUTER_RADIUS;
            r_inner <= RST_INNER_RADIUS;
            r_start <= RST_START_ANGLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RAY_COUNT:    r_rays  <= w_rays_wr;
                CFG_OUTER_RADIUS: r_outer <= w_rad_wr;
                CFG_INNER_RADIUS: r_inner <= w_rad_wr;
                CFG_START_ANGLE:  r_start <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // angle step per vertex, quotient and remainder of 65536 / (2 * rays)
    assign w_divisor = {r_rays, 1'b0};

    spvg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.load),
        .i_divisor (w_divisor),
        .o_done    (w_div_done),
        .o_quot    (w_inc_q),
        .o_rem     (w_inc_r)
    );

    // rounded offset advances by quotient, carrying the remainder
    assign w_rem_sum = {1'b0, r_rem} + {1'b0, w_inc_r};
    assign w_wrap    = (w_rem_sum >= w_divisor);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_in_item.centre_x;
            r_cy    <= i_in_item.centre_y;
            r_count <= '0;
            r_off   <= '0;
            r_rem   <= r_rays;
        end else if (i_cmd.emit) begin
            r_count <= r_count + VIDX_W'(1);
            r_off   <= r_off + w_inc_q + OFFSET_W'(w_wrap);
            r_rem   <= w_wrap ? REM_W'(w_rem_sum - w_divisor) : REM_W'(w_rem_sum);
        end
    end

    // vertex angle and scaled start vector
    assign w_radius = r_count[0] ? r_inner : r_outer;
    assign w_prod   = w_radius * INV_GAIN;
    assign w_round  = r_prod + (PROD_W'(1) << (PROD_SH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_angle <= r_start + r_off;
            r_prod  <= w_prod;
        end
    end

    spvg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.rot_start),
        .i_mag   (w_round[PROD_W-1:PROD_SH]),
        .i_angle (r_angle),
        .o_done  (w_rot_done),
        .o_x     (w_rx),
        .o_y     (w_ry)
    );

    assign w_vx = place(w_rx, r_cx);
    assign w_vy = place(w_ry, r_cy);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.vertex_x     <= w_vx;
            r_out.vertex_y     <= w_vy;
            r_out.vertex_index <= r_count;
            r_out.last_vertex  <= o_status.last;
        end
    end

    // status
    assign o_status.div_done = w_div_done;
    assign o_status.rot_done = w_rot_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = ({1'b0, r_count} == (w_divisor - DIVR_W'(1)));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/core/spvg_ctrl.sv
// controller: sequences the divide per item, then start vector, rotation and emit per vertex
// depends on spvg_pkg
module spvg_ctrl
    import spvg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_START;
            end
            S_START: begin
                o_cmd.rot_start = 1'b1;
                n_state         = S_ROT;
            end
            S_ROT: begin
                if (i_status.rot_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last ? S_IDLE : S_PREP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/star_polygon_vertex_generator.sv
// star polygon vertex generator, top level: controller plus datapath
// depends on spvg_pkg, spvg_ctrl, spvg_dp
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready | t_in_item (star centre)
//   out     | output    | o_out_valid/i_out_ready | t_out_item (one vertex)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item gives 2*rays vertices; the 65536/(2*rays) step comes first
// (17 quotient bits of the serial divider, then its done cycle), then each
// vertex passes prep, rotator start, the iterative rotation and emit.
// one item at a time; the next centre is taken once the last vertex sits in
// the output register. a stalled output holds the sequence in its emit step.
// reset is synchronous and restores the register defaults; no clearing pass.
module star_polygon_vertex_generator
    import spvg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    spvg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    spvg_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // a vertex is only loaded when the output slot is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("vertex loaded over an untaken vertex");

    // an accepted centre blocks the input until its star is done
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accepting a centre");

    // the last vertex carries the flag and frees the input
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_status.last) |=> (o_in_ready && o_out_valid
            && o_out_item.last_vertex))
        else $error("last vertex did not end the star");

    // a vertex is never emitted right after a centre is loaded
    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && $past(w_cmd.load, 1)) |-> 1'b0)
        else $error("vertex emitted without a rotation");

endmodule
